>>> design/turtle_3d_interpreter_unit_macros.svh
// ----------------------------------------------------------------------------
// Turtle 3D interpreter assertion macros
// Concurrent assertion shorthands; they expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef TURTLE_3D_INTERPRETER_UNIT_MACROS_SVH
`define TURTLE_3D_INTERPRETER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define T3D_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("turtle 3d interpreter assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define T3D_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("turtle 3d interpreter assertion failed");

`else

`define T3D_ASSERT_IMP(lbl, ante, cons)
`define T3D_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> design/t3d_pkg.sv
// ----------------------------------------------------------------------------
// Turtle 3D interpreter package
// Shared widths, frame and position types, and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package t3d_pkg;

  localparam int AXIS_W          = 18;
  localparam int POS_W           = 32;
  localparam int SYM_W           = 8;
  localparam int MASK_W          = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int PROD_W          = 2 * AXIS_W;
  localparam int POS_FRAC_BITS   = 16;
  localparam int STACK_DEPTH_DEF = 64;

  typedef logic signed [AXIS_W-1:0] axis_t;

  localparam axis_t AXIS_ONE = 18'sd65536;
  localparam axis_t AXIS_MAX = 18'sd131071;
  localparam axis_t AXIS_MIN = 18'sh20000;

  typedef struct packed {
    axis_t x;
    axis_t y;
    axis_t z;
  } axis_vec_t;

  typedef struct packed {
    axis_vec_t h;
    axis_vec_t l;
    axis_vec_t u;
  } frame_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } pos_t;

  localparam frame_t FRAME_RESET = '{
    h: '{x: AXIS_ONE, y: '0, z: '0},
    l: '{x: '0, y: AXIS_ONE, z: '0},
    u: '{x: '0, y: '0, z: AXIS_ONE}
  };

  // Request to the rotation unit: load the products this cycle.
  typedef struct packed {
    logic valid;
    logic neg_s;
  } rot_req_t;

  typedef enum logic [1:0] {
    ST_SEGMENT   = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS    = 2'd0,
    CFG_SIN    = 2'd1,
    CFG_LETTER = 2'd2,
    CFG_DRAW   = 2'd3
  } cfg_idx_t;

  localparam logic [SYM_W-1:0] SYM_YAW_L   = 8'h2B;  // +
  localparam logic [SYM_W-1:0] SYM_YAW_R   = 8'h2D;  // -
  localparam logic [SYM_W-1:0] SYM_PITCH_U = 8'h5E;  // ^
  localparam logic [SYM_W-1:0] SYM_PITCH_D = 8'h26;  // &
  localparam logic [SYM_W-1:0] SYM_ROLL_L  = 8'h5C;  // backslash
  localparam logic [SYM_W-1:0] SYM_ROLL_R  = 8'h2F;  // /
  localparam logic [SYM_W-1:0] SYM_TURN    = 8'h7C;  // |
  localparam logic [SYM_W-1:0] SYM_PUSH    = 8'h28;  // (
  localparam logic [SYM_W-1:0] SYM_POP     = 8'h29;  // )

  function automatic axis_t vec_get(input axis_vec_t v, input logic [1:0] k);
    axis_t r;
    case (k)
      2'd0:    r = v.x;
      2'd1:    r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/t3d_rotator.sv
// ----------------------------------------------------------------------------
// Turtle 3D frame rotator
// Rotates two frame axes by the turn angle: products registered, then summed,
// rounded half up to Q1.16 and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module t3d_rotator
  import t3d_pkg::*;
(
  input  wire logic      clk,
  input  wire rot_req_t  req,
  input  wire axis_vec_t axis_a,
  input  wire axis_vec_t axis_b,
  input  wire axis_t     cos_val,
  input  wire axis_t     sin_val,
  output axis_vec_t      new_a,
  output axis_vec_t      new_b
);

  localparam int SUM_W = PROD_W + 1;

  logic signed [PROD_W-1:0] p_ac_r [3];
  logic signed [PROD_W-1:0] p_bs_r [3];
  logic signed [PROD_W-1:0] p_bc_r [3];
  logic signed [PROD_W-1:0] p_as_r [3];
  logic                     neg_r;

  axis_t na_c [3];
  axis_t nb_c [3];

  function automatic axis_t sat_round(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    axis_t                   res;
    r = (v + SUM_W'(32768)) >>> 16;
    if (r > SUM_W'(AXIS_MAX)) begin
      res = AXIS_MAX;
    end else if (r < SUM_W'(AXIS_MIN)) begin
      res = AXIS_MIN;
    end else begin
      res = r[AXIS_W-1:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (req.valid) begin
      neg_r <= req.neg_s;
      for (int k = 0; k < 3; k++) begin
        p_ac_r[k] <= vec_get(axis_a, 2'(k)) * cos_val;
        p_bs_r[k] <= vec_get(axis_b, 2'(k)) * sin_val;
        p_bc_r[k] <= vec_get(axis_b, 2'(k)) * cos_val;
        p_as_r[k] <= vec_get(axis_a, 2'(k)) * sin_val;
      end
    end
  end

  // a' = a*c + b*s and b' = b*c - a*s, with s negated when neg_r is set.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (neg_r) begin
        na_c[k] = sat_round(SUM_W'(p_ac_r[k]) - SUM_W'(p_bs_r[k]));
        nb_c[k] = sat_round(SUM_W'(p_bc_r[k]) + SUM_W'(p_as_r[k]));
      end else begin
        na_c[k] = sat_round(SUM_W'(p_ac_r[k]) + SUM_W'(p_bs_r[k]));
        nb_c[k] = sat_round(SUM_W'(p_bc_r[k]) - SUM_W'(p_as_r[k]));
      end
    end
  end

  assign new_a = {na_c[0], na_c[1], na_c[2]};
  assign new_b = {nb_c[0], nb_c[1], nb_c[2]};

endmodule

`default_nettype wire

>>> design/turtle_3d_interpreter_unit.sv
// ----------------------------------------------------------------------------
// Turtle 3D interpreter unit
// Interprets L-system command symbols with a 3D turtle and emits segments.
// ----------------------------------------------------------------------------
// Each accepted symbol passes through an execute state that decodes it,
// moves the pen, issues the stack memory access and registers the rotation
// products, and an apply state that writes the rotated axes or the popped
// state back and loads the result register. The next symbol is taken in the
// apply state, once the last has left execute; the apply state is there as
// the rotation products and the stack memory read are registered. A waiting
// result stalls only a later symbol that has a result of its own. Moves,
// stack faults and unknown symbols give one result each; turns, pushes and
// pops give none. The stack needs no clearing after reset.
`default_nettype none

`include "turtle_3d_interpreter_unit_macros.svh"

module turtle_3d_interpreter_unit
  import t3d_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MASK_W-1:0]    cfg_wdata,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [SYM_W-1:0]     in_symbol,
  input  wire logic                 in_restart,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [POS_W-1:0]   out_start_x,
  output logic signed [POS_W-1:0]   out_start_y,
  output logic signed [POS_W-1:0]   out_start_z,
  output logic signed [POS_W-1:0]   out_end_x,
  output logic signed [POS_W-1:0]   out_end_y,
  output logic signed [POS_W-1:0]   out_end_z,
  output logic                      out_visible,
  output logic [1:0]                out_status
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_APPLY} state_t;
  typedef enum logic [1:0] {A_NONE, A_ROT, A_POP, A_RESULT} apply_t;
  typedef enum logic [1:0] {PAIR_HL, PAIR_HU, PAIR_LU} pair_t;

  typedef struct packed {
    pos_t   pos;
    frame_t frame;
  } stack_entry_t;

  state_t           state_r;
  logic [SYM_W-1:0] sym_r;
  pos_t             pen_r;
  frame_t           frame_r;
  logic [DW-1:0]    depth_r;
  axis_t            cos_r;
  axis_t            sin_r;
  logic [MASK_W-1:0] lmask_r;
  logic [MASK_W-1:0] dmask_r;

  apply_t           apply_kind_r;
  pair_t            pair_r;
  pos_t             pend_start_r;
  pos_t             pend_end_r;
  logic             pend_vis_r;
  status_t          pend_status_r;

  logic             out_valid_r;
  pos_t             out_start_r;
  pos_t             out_end_r;
  logic             out_vis_r;
  status_t          out_status_r;

  stack_entry_t     stack_mem [STACK_DEPTH];
  stack_entry_t     rd_data_r;

  // Execute-cycle decode
  apply_t   ex_kind;
  pair_t    ex_pair;
  logic     ex_neg;
  status_t  ex_status;
  logic     ex_flip;
  logic     ex_push;
  logic     ex_pop;
  logic     ex_move;
  logic     is_letter;
  logic     stack_full;

  logic          in_fire;
  logic          apply_go;
  logic [DW-1:0] depth_m1;
  logic          mem_we;
  logic          mem_re;

  rot_req_t  rot_req;
  axis_vec_t rot_a;
  axis_vec_t rot_b;
  axis_vec_t rot_new_a;
  axis_vec_t rot_new_b;

  logic [POS_W-1:0] delta [3];
  pos_t             pen_end;

  function automatic axis_t neg_sat(input axis_t v);
    return (v == AXIS_MIN) ? AXIS_MAX : -v;
  endfunction

  function automatic axis_vec_t vec_neg(input axis_vec_t v);
    axis_vec_t r;
    r.x = neg_sat(v.x);
    r.y = neg_sat(v.y);
    r.z = neg_sat(v.z);
    return r;
  endfunction

  assign stack_full = (depth_r == DW'(STACK_DEPTH));
  assign is_letter  = (sym_r[7:6] == 2'b01) && lmask_r[sym_r[5:0]];
  assign depth_m1   = depth_r - DW'(1);

  always_comb begin
    ex_kind   = A_NONE;
    ex_pair   = PAIR_HL;
    ex_neg    = 1'b0;
    ex_status = ST_SEGMENT;
    ex_flip   = 1'b0;
    ex_push   = 1'b0;
    ex_pop    = 1'b0;
    ex_move   = 1'b0;
    case (sym_r)
      SYM_YAW_L: begin
        ex_kind = A_ROT;
      end
      SYM_YAW_R: begin
        ex_kind = A_ROT;
        ex_neg  = 1'b1;
      end
      SYM_PITCH_U: begin
        ex_kind = A_ROT;
        ex_pair = PAIR_HU;
      end
      SYM_PITCH_D: begin
        ex_kind = A_ROT;
        ex_pair = PAIR_HU;
        ex_neg  = 1'b1;
      end
      SYM_ROLL_L: begin
        ex_kind = A_ROT;
        ex_pair = PAIR_LU;
        ex_neg  = 1'b1;
      end
      SYM_ROLL_R: begin
        ex_kind = A_ROT;
        ex_pair = PAIR_LU;
      end
      SYM_TURN: begin
        ex_flip = 1'b1;
      end
      SYM_PUSH: begin
        if (stack_full) begin
          ex_kind   = A_RESULT;
          ex_status = ST_OVERFLOW;
        end else begin
          ex_push = 1'b1;
        end
      end
      SYM_POP: begin
        if (depth_r == '0) begin
          ex_kind   = A_RESULT;
          ex_status = ST_UNDERFLOW;
        end else begin
          ex_kind = A_POP;
          ex_pop  = 1'b1;
        end
      end
      default: begin
        ex_kind = A_RESULT;
        if (is_letter) begin
          ex_move = 1'b1;
        end else begin
          ex_status = ST_UNKNOWN;
        end
      end
    endcase
  end

  always_comb begin
    case (ex_pair)
      PAIR_HL: begin
        rot_a = frame_r.h;
        rot_b = frame_r.l;
      end
      PAIR_HU: begin
        rot_a = frame_r.h;
        rot_b = frame_r.u;
      end
      default: begin
        rot_a = frame_r.l;
        rot_b = frame_r.u;
      end
    endcase
  end

  assign rot_req.valid = (state_r == S_EXEC) && (ex_kind == A_ROT);
  assign rot_req.neg_s = ex_neg;

  t3d_rotator u_rotator (
    .clk     (clk),
    .req     (rot_req),
    .axis_a  (rot_a),
    .axis_b  (rot_b),
    .cos_val (cos_r),
    .sin_val (sin_r),
    .new_a   (rot_new_a),
    .new_b   (rot_new_b)
  );

  // Pen step: heading component scaled to POS_FRAC_BITS fraction bits, rounded half up when narrowing.
  for (genvar k = 0; k < 3; k++) begin : g_delta
    logic signed [POS_W-1:0] hx;
    assign hx = POS_W'(vec_get(frame_r.h, 2'(k)));
    if (POS_FRAC_BITS >= 16) begin : g_up
      assign delta[k] = hx <<< (POS_FRAC_BITS - 16);
    end else begin : g_down
      logic signed [POS_W-1:0] biased;
      assign biased   = hx + (POS_W'(1) <<< (15 - POS_FRAC_BITS));
      assign delta[k] = biased >>> (16 - POS_FRAC_BITS);
    end
  end

  assign pen_end.x = pen_r.x + delta[0];
  assign pen_end.y = pen_r.y + delta[1];
  assign pen_end.z = pen_r.z + delta[2];

  assign apply_go = (apply_kind_r != A_RESULT) || !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_APPLY) && apply_go);
  assign in_fire  = in_valid && in_ready;

  assign mem_we = (state_r == S_EXEC) && ex_push;
  assign mem_re = (state_r == S_EXEC) && ex_pop;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[depth_r[AW-1:0]] <= '{pos: pen_r, frame: frame_r};
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[depth_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pen_r       <= '0;
      frame_r     <= FRAME_RESET;
      depth_r     <= '0;
      cos_r       <= AXIS_ONE;
      sin_r       <= '0;
      lmask_r     <= '0;
      dmask_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_COS:    cos_r   <= cfg_wdata[AXIS_W-1:0];
          CFG_SIN:    sin_r   <= cfg_wdata[AXIS_W-1:0];
          CFG_LETTER: lmask_r <= cfg_wdata;
          CFG_DRAW:   dmask_r <= cfg_wdata;
          default:    ;
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_EXEC: begin
          state_r       <= S_APPLY;
          apply_kind_r  <= ex_kind;
          pair_r        <= ex_pair;
          pend_status_r <= ex_status;
          pend_vis_r    <= ex_move & dmask_r[sym_r[5:0]];
          pend_start_r  <= ex_move ? pen_r : '0;
          pend_end_r    <= ex_move ? pen_end : '0;
          if (ex_move) begin
            pen_r <= pen_end;
          end
          if (ex_flip) begin
            frame_r.h <= vec_neg(frame_r.h);
            frame_r.l <= vec_neg(frame_r.l);
          end
          if (ex_push) begin
            depth_r <= depth_r + DW'(1);
          end
          if (ex_pop) begin
            depth_r <= depth_m1;
          end
        end
        S_APPLY: begin
          if (apply_go) begin
            state_r <= S_IDLE;
            case (apply_kind_r)
              A_ROT: begin
                case (pair_r)
                  PAIR_HL: begin
                    frame_r.h <= rot_new_a;
                    frame_r.l <= rot_new_b;
                  end
                  PAIR_HU: begin
                    frame_r.h <= rot_new_a;
                    frame_r.u <= rot_new_b;
                  end
                  default: begin
                    frame_r.l <= rot_new_a;
                    frame_r.u <= rot_new_b;
                  end
                endcase
              end
              A_POP: begin
                pen_r   <= rd_data_r.pos;
                frame_r <= rd_data_r.frame;
              end
              A_RESULT: begin
                out_valid_r  <= 1'b1;
                out_start_r  <= pend_start_r;
                out_end_r    <= pend_end_r;
                out_vis_r    <= pend_vis_r;
                out_status_r <= pend_status_r;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase

      // A restart clears the turtle ahead of the new symbol; it overrides
      // whatever the previous symbol writes back in the same cycle.
      if (in_fire) begin
        state_r <= S_EXEC;
        sym_r   <= in_symbol;
        if (in_restart) begin
          pen_r   <= '0;
          frame_r <= FRAME_RESET;
          depth_r <= '0;
        end
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_start_x = out_start_r.x;
  assign out_start_y = out_start_r.y;
  assign out_start_z = out_start_r.z;
  assign out_end_x   = out_end_r.x;
  assign out_end_y   = out_end_r.y;
  assign out_end_z   = out_end_r.z;
  assign out_visible = out_vis_r;
  assign out_status  = out_status_r;

  `T3D_ASSERT_IMP(a_depth_bound, 1'b1, depth_r <= DW'(STACK_DEPTH))
  `T3D_ASSERT_IMP(a_no_accept_in_exec, state_r == S_EXEC, !in_ready)
  `T3D_ASSERT_NXT(a_accept_to_exec, in_valid && in_ready, state_r == S_EXEC)
  `T3D_ASSERT_IMP(a_result_from_apply, $rose(out_valid_r), $past(state_r == S_APPLY))

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Turtle 3D interpreter testbench
// Streams command symbols into the interpreter under random flow control and
// checks every segment and fault result against an in-bench turtle predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import t3d_pkg::*;

  localparam int STACK_DEPTH   = STACK_DEPTH_DEF;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 215;
  localparam int NUM_PHASES    = 8;

  // Frame layout: heading, left and up axes, three components each.
  localparam int AX_H = 0;
  localparam int AX_L = 3;
  localparam int AX_U = 6;

  localparam logic [SYM_W-1:0] MOVE_DRAW    = 8'h46;  // F
  localparam logic [SYM_W-1:0] MOVE_SKIP    = 8'h66;  // f
  localparam logic [SYM_W-1:0] LTR_LOWEST   = 8'h40;
  localparam logic [SYM_W-1:0] LTR_HIGHEST  = 8'h7F;
  localparam logic [SYM_W-1:0] LTR_UNMARKED = 8'h42;  // B
  localparam logic [MASK_W-1:0] BASE_LETTERS =
      (64'd1 << (MOVE_DRAW - LTR_LOWEST)) | (64'd1 << (MOVE_SKIP - LTR_LOWEST));

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             restart;
  } symbol_item_t;

  typedef struct packed {
    pos_t    start_pt;
    pos_t    end_pt;
    logic    visible;
    status_t status;
  } segment_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [MASK_W-1:0]     cfg_wdata  = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [SYM_W-1:0]      in_symbol  = '0;
  logic                  in_restart = 1'b0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic signed [POS_W-1:0] out_start_x, out_start_y, out_start_z;
  logic signed [POS_W-1:0] out_end_x, out_end_y, out_end_z;
  logic                  out_visible;
  logic [1:0]            out_status;

  turtle_3d_interpreter_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_symbol   (in_symbol),
    .in_restart  (in_restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_start_x (out_start_x),
    .out_start_y (out_start_y),
    .out_start_z (out_start_z),
    .out_end_x   (out_end_x),
    .out_end_y   (out_end_y),
    .out_end_z   (out_end_z),
    .out_visible (out_visible),
    .out_status  (out_status)
  );

  always #1 clk = ~clk;

  // Predictor state: configuration copy, pen, frame and the saved-state stack.
  logic [AXIS_W-1:0]  cos_reg;
  logic [AXIS_W-1:0]  sin_reg;
  logic [MASK_W-1:0]  letter_reg;
  logic [MASK_W-1:0]  draw_reg;
  logic [POS_W-1:0]   pen [3];
  axis_t              frame [9];
  logic [POS_W-1:0]   saved_pen [STACK_DEPTH][3];
  axis_t              saved_frame [STACK_DEPTH][9];
  int unsigned        pen_depth;

  symbol_item_t pending_symbols [$];
  segment_t     expected_segments [$];

  bit in_taken  = 1'b0;
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  bit hold_req  = 1'b0;
  int src_gap   = 0;
  int snk_gap   = 0;
  int hold_left = 0;
  int gen_depth = 0;
  int queued_cnt = 0;
  int accepted_cnt = 0;
  int checked_cnt = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int status_cnt [4] = '{0, 0, 0, 0};

  function automatic axis_t clamp_axis(input longint v);
    if (v > longint'(AXIS_MAX)) return AXIS_MAX;
    if (v < longint'(AXIS_MIN)) return AXIS_MIN;
    return axis_t'(v[AXIS_W-1:0]);
  endfunction

  task automatic clear_turtle;
    for (int k = 0; k < 3; k++) pen[k] = '0;
    for (int k = 0; k < 9; k++) frame[k] = '0;
    frame[AX_H] = AXIS_ONE;
    frame[AX_L + 1] = AXIS_ONE;
    frame[AX_U + 2] = AXIS_ONE;
    pen_depth = 0;
  endtask

  // a' = a*c + b*s and b' = b*c - a*s on each component, rounded half up.
  task automatic turn_pair(input int a_base, input int b_base, input longint c,
                           input longint s);
    longint a, b;
    for (int k = 0; k < 3; k++) begin
      a = frame[a_base + k];
      b = frame[b_base + k];
      frame[a_base + k] = clamp_axis((a * c + b * s + 32768) >>> 16);
      frame[b_base + k] = clamp_axis((b * c - a * s + 32768) >>> 16);
    end
  endtask

  task automatic interpret_symbol(input logic [SYM_W-1:0] sym, input logic restart);
    segment_t         seg;
    bit               emits;
    longint           c, s, delta;
    logic [POS_W-1:0] st [3];
    logic [POS_W-1:0] en [3];
    seg.start_pt = '0;
    seg.end_pt   = '0;
    seg.visible  = 1'b0;
    seg.status   = ST_SEGMENT;
    emits = 1'b0;
    c = longint'($signed(cos_reg));
    s = longint'($signed(sin_reg));
    if (restart) clear_turtle();
    case (sym)
      SYM_YAW_L:   turn_pair(AX_H, AX_L, c, s);
      SYM_YAW_R:   turn_pair(AX_H, AX_L, c, -s);
      SYM_PITCH_U: turn_pair(AX_H, AX_U, c, s);
      SYM_PITCH_D: turn_pair(AX_H, AX_U, c, -s);
      SYM_ROLL_L:  turn_pair(AX_L, AX_U, c, -s);
      SYM_ROLL_R:  turn_pair(AX_L, AX_U, c, s);
      SYM_TURN: begin
        for (int k = 0; k < 6; k++) frame[k] = clamp_axis(-longint'(frame[k]));
      end
      SYM_PUSH: begin
        if (pen_depth >= STACK_DEPTH) begin
          seg.status = ST_OVERFLOW;
          emits = 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) saved_pen[pen_depth][k] = pen[k];
          for (int k = 0; k < 9; k++) saved_frame[pen_depth][k] = frame[k];
          pen_depth++;
        end
      end
      SYM_POP: begin
        if (pen_depth == 0) begin
          seg.status = ST_UNDERFLOW;
          emits = 1'b1;
        end else begin
          pen_depth--;
          for (int k = 0; k < 3; k++) pen[k] = saved_pen[pen_depth][k];
          for (int k = 0; k < 9; k++) frame[k] = saved_frame[pen_depth][k];
        end
      end
      default: begin
        emits = 1'b1;
        if (sym[7:6] != 2'b01 || !letter_reg[sym[5:0]]) begin
          seg.status = ST_UNKNOWN;
        end else begin
          for (int k = 0; k < 3; k++) begin
            delta = ((longint'(frame[AX_H + k]) <<< POS_FRAC_BITS) + 32768) >>> 16;
            st[k] = pen[k];
            en[k] = pen[k] + delta[POS_W-1:0];
            pen[k] = en[k];
          end
          seg.start_pt = '{x: st[0], y: st[1], z: st[2]};
          seg.end_pt   = '{x: en[0], y: en[1], z: en[2]};
          seg.visible  = draw_reg[sym[5:0]];
        end
      end
    endcase
    if (emits) begin
      expected_segments.insert(expected_segments.size(), seg);
      status_cnt[seg.status]++;
    end
  endtask

  task automatic check_field(input string name, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  function automatic int pick_idle(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Input side: a new item goes out only after the previous one transferred.
  always @(negedge clk) begin : drv_blk
    symbol_item_t item;
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pending_symbols.size() > 0) begin
        item = pending_symbols.pop_front();
        in_valid   <= 1'b1;
        in_symbol  <= item.symbol;
        in_restart <= item.restart;
        src_gap = pick_idle(src_idle_en);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: random back-pressure plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) snk_gap = pick_idle(snk_idle_en);
    end
  end

  always @(posedge clk) begin : mon_blk
    segment_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        interpret_symbol(in_symbol, in_restart);
        in_taken = 1'b1;
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        if (expected_segments.size() == 0) begin
          $error("result transfer with nothing pending: status %0d", out_status);
          fail_cnt++;
        end else begin
          want = expected_segments.pop_front();
          check_field("start_x", want.start_pt.x, out_start_x);
          check_field("start_y", want.start_pt.y, out_start_y);
          check_field("start_z", want.start_pt.z, out_start_z);
          check_field("end_x", want.end_pt.x, out_end_x);
          check_field("end_y", want.end_pt.y, out_end_y);
          check_field("end_z", want.end_pt.z, out_end_z);
          check_field("visible", POS_W'(want.visible), POS_W'(out_visible));
          check_field("status", POS_W'(want.status), POS_W'(out_status));
          checked_cnt++;
        end
      end
    end
  end

  task automatic add_item(input logic [SYM_W-1:0] sym, input logic restart);
    symbol_item_t it;
    it.symbol  = sym;
    it.restart = restart;
    pending_symbols.insert(pending_symbols.size(), it);
    queued_cnt++;
    if (restart) gen_depth = 0;
    if (sym == SYM_PUSH && gen_depth < STACK_DEPTH) gen_depth++;
    else if (sym == SYM_POP && gen_depth > 0) gen_depth--;
  endtask

  function automatic logic [SYM_W-1:0] pick_turn;
    case ($urandom_range(0, 6))
      0: return SYM_YAW_L;
      1: return SYM_YAW_R;
      2: return SYM_PITCH_U;
      3: return SYM_PITCH_D;
      4: return SYM_ROLL_L;
      5: return SYM_ROLL_R;
      default: return SYM_TURN;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] pick_letter;
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return MOVE_DRAW;
    if (r < 6) return MOVE_SKIP;
    return SYM_W'(LTR_LOWEST + $urandom_range(0, 63));
  endfunction

  // Pushes past the stack limit, then pops past empty, with turns and moves in between.
  task automatic deep_stack;
    for (int k = 0; k < STACK_DEPTH + 2; k++) begin
      add_item(SYM_PUSH, 1'b0);
      if ($urandom_range(0, 3) == 0) add_item(pick_turn(), 1'b0);
      if ($urandom_range(0, 3) == 0) add_item(MOVE_DRAW, 1'b0);
    end
    for (int k = 0; k < STACK_DEPTH + 2; k++) begin
      add_item(SYM_POP, 1'b0);
      if ($urandom_range(0, 2) == 0) add_item(pick_letter(), 1'b0);
    end
  endtask

  // Mostly well-formed turtle programs with balanced branches, some noise.
  task automatic gen_random(input int n);
    int   stop_at;
    int   r;
    logic rs;
    stop_at = queued_cnt + n;
    while (queued_cnt < stop_at) begin
      r = $urandom_range(0, 999);
      rs = ($urandom_range(0, 49) == 0);
      if (r < 2) deep_stack();
      else if (r < 60) add_item(SYM_W'($urandom_range(0, 255)), rs);
      else if (r < 380) add_item(pick_letter(), rs);
      else if (r < 650) add_item(pick_turn(), rs);
      else if (r < 820) add_item(gen_depth < STACK_DEPTH ? SYM_PUSH : pick_letter(), rs);
      else add_item(gen_depth > 0 ? SYM_POP : pick_turn(), rs);
    end
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [MASK_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COS:    cos_reg = data[AXIS_W-1:0];
      CFG_SIN:    sin_reg = data[AXIS_W-1:0];
      CFG_LETTER: letter_reg = data;
      default:    draw_reg = data;
    endcase
  endtask

  // Both the input queue and the pending results must empty before moving on.
  task automatic drain;
    while (pending_symbols.size() > 0 || in_valid || expected_segments.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : sequencer
    longint      cs, sn;
    logic [63:0] lm, dm;
    cos_reg    = 18'd65536;
    sin_reg    = '0;
    letter_reg = '0;
    draw_reg   = '0;
    for (int k = 0; k < STACK_DEPTH; k++) begin
      for (int j = 0; j < 3; j++) saved_pen[k][j] = '0;
      for (int j = 0; j < 9; j++) saved_frame[k][j] = '0;
    end
    clear_turtle();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Register reset values: no letters, identity turn.
    add_item(MOVE_DRAW, 1'b0);
    add_item(SYM_YAW_L, 1'b0);
    add_item(MOVE_DRAW, 1'b0);
    drain();

    // Quarter turns, a small alphabet including both ends of the letter range.
    cfg_write(CFG_COS, 64'd0);
    cfg_write(CFG_SIN, 64'd65536);
    cfg_write(CFG_LETTER, BASE_LETTERS | 64'd1 | (64'd1 << 63));
    cfg_write(CFG_DRAW, (64'd1 << (MOVE_DRAW - LTR_LOWEST)) | (64'd1 << 63));
    add_item(MOVE_DRAW, 1'b1);
    add_item(SYM_YAW_L, 1'b0);
    add_item(MOVE_DRAW, 1'b0);
    add_item(SYM_YAW_R, 1'b0);
    add_item(MOVE_DRAW, 1'b0);
    add_item(SYM_PITCH_U, 1'b0);
    add_item(MOVE_DRAW, 1'b0);
    add_item(SYM_PITCH_D, 1'b0);
    add_item(MOVE_DRAW, 1'b0);
    add_item(SYM_ROLL_L, 1'b0);
    add_item(MOVE_DRAW, 1'b0);
    add_item(SYM_ROLL_R, 1'b0);
    add_item(MOVE_DRAW, 1'b0);
    add_item(SYM_TURN, 1'b0);
    add_item(MOVE_DRAW, 1'b0);
    add_item(SYM_PUSH, 1'b0);
    add_item(MOVE_SKIP, 1'b0);
    add_item(SYM_POP, 1'b0);
    add_item(SYM_POP, 1'b0);
    add_item(LTR_LOWEST, 1'b0);
    add_item(LTR_HIGHEST, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b1);
    add_item(LTR_UNMARKED, 1'b0);
    add_item(SYM_PUSH, 1'b0);
    add_item(MOVE_DRAW, 1'b1);
    add_item(SYM_POP, 1'b0);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      lm = {$urandom, $urandom} | BASE_LETTERS;
      dm = {$urandom, $urandom};
      case (ph)
        0: begin cs = 65536;  sn = 0;      lm = '1; end
        1: begin cs = -65536; sn = 0;      end
        2: begin cs = 0;      sn = 65536;  dm = '1; end
        3: begin cs = 46341;  sn = 46341;  end
        4: begin cs = 65536;  sn = 65536;  dm = '0; end
        5: begin cs = -65536; sn = -65536; lm = '0; end
        6: begin cs = 0;      sn = -65536; end
        default: begin
          cs = longint'($urandom_range(0, 131072)) - 65536;
          sn = longint'($urandom_range(0, 131072)) - 65536;
        end
      endcase
      cfg_write(CFG_COS, 64'(cs));
      cfg_write(CFG_SIN, 64'(sn));
      cfg_write(CFG_LETTER, lm);
      cfg_write(CFG_DRAW, dm);
      // One phase runs without any idling, two idle on one side only.
      src_idle_en = (ph != 2) && (ph != 6);
      snk_idle_en = (ph != 2) && (ph != 5);
      if (ph == 4) deep_stack();
      gen_random(PHASE_ITEMS);
      // The output stalls long enough for the interpreter to back up its input.
      if (ph == 3) hold_req = 1'b1;
      drain();
    end

    $display("Interpreted %0d symbols over %0d angle settings, %0d results checked.",
             accepted_cnt, NUM_PHASES + 2, checked_cnt);
    $display("Segments %0d, unknown %0d, underflow %0d, overflow %0d.",
             status_cnt[ST_SEGMENT], status_cnt[ST_UNKNOWN],
             status_cnt[ST_UNDERFLOW], status_cnt[ST_OVERFLOW]);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
